/* src/cecr_pkg.sv */
// ----------------------------------------------------------------------------
// cecr_pkg: shared types and constants of the CEC register block
// Register map offsets, control word bit positions, request codes and the
// address decode record passed from the decoder to the core.
// ----------------------------------------------------------------------------
`default_nettype none

package cecr_pkg;

    localparam int unsigned ADDR_W = 6;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = 21;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned CFG_IDX_W = 3;

    // Request codes
    localparam logic [2:0] REQ_READ  = 3'd0;
    localparam logic [2:0] REQ_WRITE = 3'd1;
    localparam logic [2:0] REQ_TICK  = 3'd2;
    localparam logic [2:0] REQ_PLUG  = 3'd3;
    localparam logic [2:0] REQ_RX    = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_ACK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_NACK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONN_RST   = 3'd4;

    // Register map
    localparam logic [ADDR_W-1:0] CTL1_OFF = 6'h10;
    localparam logic [ADDR_W-1:0] CTL2_OFF = 6'h14;
    localparam logic [ADDR_W-1:0] CTL5_OFF = 6'h20;
    localparam logic [ADDR_W-1:0] TXD_OFF  = 6'h28;
    localparam logic [ADDR_W-1:0] RXD_OFF  = 6'h38;

    localparam logic [2:0] CTL5_IDX = 3'd4;

    // Control word bits
    localparam logic [WORD_W-1:0] TX_EOM   = 32'h8000_0000;
    localparam logic [WORD_W-1:0] TX_GOOD  = 32'h4000_0000;
    localparam logic [WORD_W-1:0] RX_EOM   = 32'h2000_0000;
    localparam logic [WORD_W-1:0] RX_GOOD  = 32'h1000_0000;
    localparam logic [WORD_W-1:0] RX_WCNT  = 32'h0f00_0000;
    localparam logic [WORD_W-1:0] TX_SWRST = 32'h0800_0000;
    localparam logic [WORD_W-1:0] RX_SWRST = 32'h0400_0000;
    localparam logic [WORD_W-1:0] RX_INT   = 32'h0080_0000;
    localparam logic [WORD_W-1:0] CLR_RX   = 32'h0020_0000;
    localparam logic [WORD_W-1:0] START_TX = 32'h0010_0000;

    localparam logic [WORD_W-1:0] RX_STATUS   = RX_EOM | RX_GOOD | RX_WCNT;
    localparam logic [WORD_W-1:0] STATUS_BITS = TX_EOM | TX_GOOD | RX_STATUS;

    localparam logic [3:0] DEST_BCAST = 4'hf;

    typedef struct packed {
        logic       rd_hit;
        logic       rd_ctl;
        logic       rd_tx;
        logic       wr_hit;
        logic       wr_ctl1;
        logic       wr_ctl;
        logic       wr_tx;
        logic [2:0] ctl_idx;
        logic [1:0] tx_idx;
        logic       rx_idx;
    } cecr_dec_t;

endpackage

`default_nettype wire

/* src/cec_controller_registers_core.sv */
// ----------------------------------------------------------------------------
// cec_controller_registers_core: CEC controller register block
// Control, transmit and receive data words, hot-plug tracking and the
// transmission countdown, driven by one request per transfer.
// ----------------------------------------------------------------------------
// Each accepted request (read, write, tick, hot-plug change, received
// message) updates the register state in the cycle it is accepted and its
// result appears on the m_ channel in the cycle after, from an output register.
// Throughput is one request per clock: s_ready stays high while the output
// register is empty or being taken in the same cycle, so a consumer that
// holds m_ready high sees one result per cycle. The transmission length
// (start_ticks plus (length+1) times byte_ticks) is computed by a small 5x16
// multiply at the moment the start bit rises, and ticks then count it down.
// The configuration port is a plain write port; connected_at_reset is
// accepted but nothing samples it, and reset always restores the hot-plug
// level to connected, whatever was written.
// ----------------------------------------------------------------------------
`default_nettype none

module cec_controller_registers_core
    import cecr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [2:0]           s_req_type,
    input  wire logic [ADDR_W-1:0]    s_address,
    input  wire logic [WORD_W-1:0]    s_write_data,
    input  wire logic                 s_plug_level,
    input  wire logic [7:0]           s_rx_length,
    input  wire logic [63:0]          s_rx_bytes_low,
    input  wire logic [63:0]          s_rx_bytes_high,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [WORD_W-1:0]         m_read_data,
    output logic                      m_bad_offset,
    output logic                      m_plug_now,
    output logic                      m_plug_pulse,
    output logic                      m_unplug_pulse,
    output logic                      m_tx_done_pulse,
    output logic                      m_rx_pulse
);

    // configuration
    logic [CFG_W-1:0] peer_ack_reg;
    logic             force_nack_reg;
    logic [CFG_W-1:0] start_ticks_reg;
    logic [CFG_W-1:0] byte_ticks_reg;

    // block state
    logic              plugged_reg,  plugged_next;
    logic [WORD_W-1:0] ctl_reg  [5];
    logic [WORD_W-1:0] ctl_next [5];
    logic [WORD_W-1:0] tx_reg   [4];
    logic [WORD_W-1:0] tx_next  [4];
    logic [WORD_W-1:0] rx_reg   [4];
    logic [WORD_W-1:0] rx_next  [4];
    logic              busy_reg,     busy_next;
    logic [CNT_W-1:0]  count_reg,    count_next;

    // output register
    logic              m_valid_reg,  m_valid_next;
    logic [WORD_W-1:0] rdata_reg;
    logic              bad_reg;
    logic              plug_now_reg;
    logic              pp_reg;
    logic              up_reg;
    logic              txd_reg;
    logic              rxp_reg;

    // result of the current request
    logic [WORD_W-1:0] rdata;
    logic              bad;
    logic              pp;
    logic              up;
    logic              txd;
    logic              rxp;

    logic              accept;
    cecr_dec_t         dec;

    // transmission duration and end-of-transmission checks
    logic [4:0]        tx_len;
    logic [CNT_W-1:0]  tx_bytes_ticks;
    logic [CNT_W-1:0]  tx_duration;
    logic [3:0]        dest;
    logic              ack;
    logic              rx_ok;
    logic [3:0]        rx_wcnt;

    cecr_decode u_decode (
        .address (s_address),
        .dec     (dec)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // length field comes from the word just written (not a status bit)
    assign tx_len         = {1'b0, s_write_data[19:16]} + 5'd1;
    assign tx_bytes_ticks = CNT_W'(tx_len) * CNT_W'(byte_ticks_reg);
    assign tx_duration    = CNT_W'(start_ticks_reg) + tx_bytes_ticks;

    assign dest = tx_reg[0][3:0];
    assign ack  = (dest == DEST_BCAST) || peer_ack_reg[dest];

    assign rx_ok = (s_rx_length != 8'd0) && (s_rx_length <= 8'd16) && plugged_reg
                   && ((ctl_reg[CTL5_IDX] & RX_SWRST) == '0);
    assign rx_wcnt = 4'(s_rx_length - 8'd1);

    // next state
    always_comb begin
        plugged_next = plugged_reg;
        ctl_next     = ctl_reg;
        tx_next      = tx_reg;
        rx_next      = rx_reg;
        busy_next    = busy_reg;
        count_next   = count_reg;
        rdata        = '0;
        bad          = 1'b0;
        pp           = 1'b0;
        up           = 1'b0;
        txd          = 1'b0;
        rxp          = 1'b0;

        if (accept) begin
            unique case (s_req_type)
                REQ_READ: begin
                    bad = !dec.rd_hit;
                    priority if (dec.rd_ctl) begin
                        rdata = ctl_reg[dec.ctl_idx];
                    end else if (dec.rd_tx) begin
                        rdata = tx_reg[dec.tx_idx];
                    end else if (dec.rd_hit) begin
                        rdata = rx_reg[{1'b0, dec.rx_idx}];
                    end else begin
                        // hole in the map: read data stays zero
                    end
                end
                REQ_WRITE: begin
                    bad = !dec.wr_hit;
                    priority if (dec.wr_ctl1) begin
                        // status bits are write-protected
                        ctl_next[0] = (ctl_reg[0] & STATUS_BITS)
                                    | (s_write_data & ~STATUS_BITS);
                        if ((s_write_data & CLR_RX) != '0) begin
                            ctl_next[0]        = ctl_next[0] & ~RX_STATUS;
                            ctl_next[CTL5_IDX] = ctl_next[CTL5_IDX] & ~RX_INT;
                        end
                        if (((s_write_data & START_TX) != '0)
                            && ((ctl_reg[0] & START_TX) == '0)) begin
                            ctl_next[0]        = ctl_next[0] & ~(TX_EOM | TX_GOOD);
                            ctl_next[CTL5_IDX] = ctl_next[CTL5_IDX] & ~RX_INT;
                            busy_next          = 1'b1;
                            count_next         = tx_duration;
                        end
                    end else if (dec.wr_ctl) begin
                        ctl_next[dec.ctl_idx] = s_write_data;
                        // software reset of either side cancels transmission
                        if ((dec.ctl_idx == CTL5_IDX)
                            && ((s_write_data & (TX_SWRST | RX_SWRST)) != '0)) begin
                            busy_next   = 1'b0;
                            count_next  = '0;
                            ctl_next[0] = ctl_reg[0] & ~STATUS_BITS;
                        end
                    end else if (dec.wr_tx) begin
                        tx_next[dec.tx_idx] = s_write_data;
                    end else begin
                        // receive words are read-only; writes are dropped
                    end
                end
                REQ_TICK: begin
                    if (busy_reg) begin
                        if ((count_reg == CNT_W'(0)) || (count_reg == CNT_W'(1))) begin
                            busy_next   = 1'b0;
                            count_next  = '0;
                            txd         = 1'b1;
                            ctl_next[0] = ctl_reg[0] | TX_EOM;
                            if (plugged_reg && ack && !force_nack_reg) begin
                                ctl_next[0] = ctl_next[0] | TX_GOOD;
                            end else begin
                                ctl_next[0] = ctl_next[0] & ~TX_GOOD;
                            end
                            ctl_next[CTL5_IDX] = ctl_reg[CTL5_IDX] & ~RX_INT;
                        end else begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
                REQ_PLUG: begin
                    if (s_plug_level != plugged_reg) begin
                        plugged_next = s_plug_level;
                        pp           = s_plug_level;
                        up           = !s_plug_level;
                    end
                end
                REQ_RX: begin
                    if (rx_ok) begin
                        rxp        = 1'b1;
                        rx_next[0] = s_rx_bytes_low[31:0];
                        rx_next[1] = (s_rx_length > 8'd4)  ? s_rx_bytes_low[63:32]  : '0;
                        rx_next[2] = (s_rx_length > 8'd8)  ? s_rx_bytes_high[31:0]  : '0;
                        rx_next[3] = (s_rx_length > 8'd12) ? s_rx_bytes_high[63:32] : '0;
                        ctl_next[0] = (ctl_reg[0] & ~RX_STATUS) | RX_EOM | RX_GOOD
                                    | {4'd0, rx_wcnt, 24'd0};
                        ctl_next[CTL5_IDX] = ctl_reg[CTL5_IDX] | RX_INT;
                    end
                end
                default: begin
                    // unused request codes change nothing
                end
            endcase
        end

        m_valid_next = s_ready ? accept : m_valid_reg;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peer_ack_reg    <= 16'd1;
            force_nack_reg  <= 1'b0;
            start_ticks_reg <= 16'd5;
            byte_ticks_reg  <= 16'd24;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PEER_ACK:   peer_ack_reg    <= cfg_wdata;
                CFG_FORCE_NACK: force_nack_reg  <= cfg_wdata[0];
                CFG_START:      start_ticks_reg <= cfg_wdata;
                CFG_BYTE:       byte_ticks_reg  <= cfg_wdata;
                CFG_CONN_RST: begin
                    // nothing samples it; reset always restores connected
                end
                default: begin
                end
            endcase
        end
    end

    // block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plugged_reg <= 1'b1;
            ctl_reg     <= '{default: '0};
            tx_reg      <= '{default: '0};
            rx_reg      <= '{default: '0};
            busy_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            plugged_reg <= plugged_next;
            ctl_reg     <= ctl_next;
            tx_reg      <= tx_next;
            rx_reg      <= rx_next;
            busy_reg    <= busy_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            rdata_reg    <= rdata;
            bad_reg      <= bad;
            plug_now_reg <= plugged_next;
            pp_reg       <= pp;
            up_reg       <= up;
            txd_reg      <= txd;
            rxp_reg      <= rxp;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_read_data     = rdata_reg;
    assign m_bad_offset    = bad_reg;
    assign m_plug_now      = plug_now_reg;
    assign m_plug_pulse    = pp_reg;
    assign m_unplug_pulse  = up_reg;
    assign m_tx_done_pulse = txd_reg;
    assign m_rx_pulse      = rxp_reg;

endmodule

`default_nettype wire

/* src/cecr_decode.sv */
// ----------------------------------------------------------------------------
// cecr_decode: register map decoder
// Turns a byte offset into read and write hit flags and word indexes.
// ----------------------------------------------------------------------------
`default_nettype none

module cecr_decode
    import cecr_pkg::*;
(
    input  wire logic [ADDR_W-1:0] address,
    output cecr_dec_t              dec
);

    logic [ADDR_W-1:0] ctl_off;
    logic [ADDR_W-1:0] tx_off;
    logic              in_ctl;
    logic              in_tx;
    logic              in_rx;
    logic              wr_ctl1;
    logic              wr_ctl;

    assign ctl_off = address - CTL1_OFF;
    assign tx_off  = address - TXD_OFF;

    assign in_ctl  = (address >= CTL1_OFF) && (address <= CTL5_OFF);
    assign in_tx   = (address >= TXD_OFF) && (address < RXD_OFF);
    assign in_rx   = (address >= RXD_OFF);
    // Unaligned writes into control word 1 hit nothing
    assign wr_ctl1 = (address == CTL1_OFF);
    assign wr_ctl  = (address >= CTL2_OFF) && (address <= CTL5_OFF);

    always_comb begin
        dec.rd_hit  = in_ctl | in_tx | in_rx;
        dec.rd_ctl  = in_ctl;
        dec.rd_tx   = in_tx;
        dec.wr_hit  = wr_ctl1 | wr_ctl | in_tx | in_rx;
        dec.wr_ctl1 = wr_ctl1;
        dec.wr_ctl  = wr_ctl;
        dec.wr_tx   = in_tx;
        dec.ctl_idx = ctl_off[4:2];
        dec.tx_idx  = tx_off[3:2];
        dec.rx_idx  = address[2];
    end

endmodule

`default_nettype wire

/* src/cecr_checker.sv */
// ----------------------------------------------------------------------------
// cecr_checker: port-level checks of the CEC register block
// Watches the result channel against accepted requests and reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cecr_checker
    import cecr_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [WORD_W-1:0] m_read_data,
    input wire logic              m_plug_now,
    input wire logic              m_plug_pulse,
    input wire logic              m_unplug_pulse
);

    // no result survives reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data))
        else $error("stalled result changed");

    // every accepted request yields a result in the next cycle
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted transfer gave no result");

    a_pulse_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_plug_pulse && m_unplug_pulse))
        else $error("plug and unplug in one result");

    a_pulse_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_plug_pulse || m_unplug_pulse) |-> (m_plug_now == m_plug_pulse))
        else $error("hot-plug pulse disagrees with level");

endmodule

bind cec_controller_registers_core cecr_checker u_cecr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_read_data    (m_read_data),
    .m_plug_now     (m_plug_now),
    .m_plug_pulse   (m_plug_pulse),
    .m_unplug_pulse (m_unplug_pulse)
);

`default_nettype wire

/* dv/tb_cec_controller_registers_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cec_controller_registers_core: self-checking bench for the CEC register block
// Drives register reads and writes, ticks, hot-plug changes and received
// messages through the s_ channel with bursty traffic. An in-bench model of
// the register state predicts every m_ result, which is checked in order.
// Several configuration settings are run, the extremes among them.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cec_controller_registers_core;
    import cecr_pkg::*;

    localparam int RAND_PER_PHASE = 190;
    localparam int N_PHASES       = 8;
    localparam int MAX_REPORTS    = 10;

    // request codes with no function, the block must ignore them
    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
        logic              level;
        logic [7:0]        rx_len;
        logic [63:0]       rx_lo;
        logic [63:0]       rx_hi;
    } cec_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] rdata;
        logic              bad;
        logic              plug;
        logic              plug_p;
        logic              unplug_p;
        logic              tx_done;
        logic              rx_p;
    } cec_rsp_t;

    // ------------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                 aclk       = 1'b0;
    logic                 aresetn    = 1'b0;
    logic                 cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [CFG_W-1:0]     cfg_wdata  = '0;
    logic                 s_valid    = 1'b0;
    logic                 s_ready;
    logic [2:0]           s_req_type = '0;
    logic [ADDR_W-1:0]    s_address  = '0;
    logic [WORD_W-1:0]    s_write_data = '0;
    logic                 s_plug_level = 1'b0;
    logic [7:0]           s_rx_length  = '0;
    logic [63:0]          s_rx_bytes_low  = '0;
    logic [63:0]          s_rx_bytes_high = '0;
    logic                 m_valid;
    logic                 m_ready    = 1'b0;
    logic [WORD_W-1:0]    m_read_data;
    logic                 m_bad_offset;
    logic                 m_plug_now;
    logic                 m_plug_pulse;
    logic                 m_unplug_pulse;
    logic                 m_tx_done_pulse;
    logic                 m_rx_pulse;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    cec_controller_registers_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_address       (s_address),
        .s_write_data    (s_write_data),
        .s_plug_level    (s_plug_level),
        .s_rx_length     (s_rx_length),
        .s_rx_bytes_low  (s_rx_bytes_low),
        .s_rx_bytes_high (s_rx_bytes_high),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_bad_offset    (m_bad_offset),
        .m_plug_now      (m_plug_now),
        .m_plug_pulse    (m_plug_pulse),
        .m_unplug_pulse  (m_unplug_pulse),
        .m_tx_done_pulse (m_tx_done_pulse),
        .m_rx_pulse      (m_rx_pulse)
    );

    // ------------------------------------------------------------------------
    // Register model: configuration copy and block state
    // ------------------------------------------------------------------------
    logic [15:0]       ack_mask;
    logic              nack_all;
    logic [15:0]       start_len;
    logic [15:0]       byte_len;
    logic              conn_rst;
    logic              hp_level;
    logic [WORD_W-1:0] ctl_w [5];
    logic [WORD_W-1:0] txd_w [4];
    logic [WORD_W-1:0] rxd_w [4];
    logic              tx_active;
    logic [CNT_W-1:0]  tx_left;

    cec_req_t req_fifo[$];
    cec_rsp_t rsp_due[$];

    int n_accepted = 0;
    int n_tx_done  = 0;
    int n_rx       = 0;
    int n_edges    = 0;
    int n_fail     = 0;

    // Applies one request to the model state and returns the result it owes.
    function automatic cec_rsp_t cec_reg_update(cec_req_t r);
        cec_rsp_t          o;
        logic [WORD_W-1:0] old;
        logic [WORD_W-1:0] span;
        logic [3:0]        dest;
        logic [127:0]      rx_all;
        int                nwords;
        o = '0;
        case (r.kind)
            REQ_READ: begin
                if (r.addr >= CTL1_OFF && r.addr <= CTL5_OFF)
                    o.rdata = ctl_w[(r.addr - CTL1_OFF) >> 2];
                else if (r.addr >= TXD_OFF && r.addr < RXD_OFF)
                    o.rdata = txd_w[(r.addr - TXD_OFF) >> 2];
                else if (r.addr >= RXD_OFF)
                    o.rdata = rxd_w[((r.addr - RXD_OFF) >> 2) & 3];
                else
                    o.bad = 1'b1;
            end
            REQ_WRITE: begin
                if (r.addr == CTL1_OFF) begin
                    old = ctl_w[0];
                    ctl_w[0] = (old & STATUS_BITS) | (r.wdata & ~STATUS_BITS);
                    if ((r.wdata & CLR_RX) != 0) begin
                        ctl_w[0] &= ~RX_STATUS;
                        ctl_w[4] &= ~RX_INT;
                    end
                    // start on a rising start bit; length field counts bytes minus one
                    if ((r.wdata & START_TX) != 0 && (old & START_TX) == 0) begin
                        span = 32'(start_len) + (32'(ctl_w[0][19:16]) + 32'd1) * 32'(byte_len);
                        ctl_w[0] &= ~(TX_EOM | TX_GOOD);
                        ctl_w[4] &= ~RX_INT;
                        tx_active = 1'b1;
                        tx_left = span[CNT_W-1:0];
                    end
                end else if (r.addr >= CTL2_OFF && r.addr <= CTL5_OFF) begin
                    ctl_w[(r.addr - CTL1_OFF) >> 2] = r.wdata;
                    if (r.addr == CTL5_OFF && (r.wdata & (TX_SWRST | RX_SWRST)) != 0) begin
                        tx_active = 1'b0;
                        tx_left = '0;
                        ctl_w[0] &= ~STATUS_BITS;
                    end
                end else if (r.addr >= TXD_OFF && r.addr < RXD_OFF) begin
                    txd_w[(r.addr - TXD_OFF) >> 2] = r.wdata;
                end else if (r.addr < RXD_OFF) begin
                    // receive words swallow writes silently, the rest is a hole
                    o.bad = 1'b1;
                end
            end
            REQ_TICK: begin
                if (tx_active) begin
                    // a zero-length countdown finishes on the first tick
                    if (tx_left != 0)
                        tx_left = tx_left - 1'b1;
                    if (tx_left == 0) begin
                        dest = txd_w[0][3:0];
                        tx_active = 1'b0;
                        ctl_w[0] |= TX_EOM;
                        if (hp_level && (dest == DEST_BCAST || ack_mask[dest]) && !nack_all)
                            ctl_w[0] |= TX_GOOD;
                        else
                            ctl_w[0] &= ~TX_GOOD;
                        ctl_w[4] &= ~RX_INT;
                        o.tx_done = 1'b1;
                        n_tx_done++;
                    end
                end
            end
            REQ_PLUG: begin
                if (r.level != hp_level) begin
                    hp_level = r.level;
                    o.plug_p = r.level;
                    o.unplug_p = !r.level;
                    n_edges++;
                end
            end
            REQ_RX: begin
                if (r.rx_len != 0 && r.rx_len <= 16 && hp_level && (ctl_w[4] & RX_SWRST) == 0) begin
                    nwords = (int'(r.rx_len) + 3) >> 2;
                    rx_all = {r.rx_hi, r.rx_lo};
                    for (int i = 0; i < 4; i++)
                        rxd_w[i] = (i < nwords) ? rx_all[32*i +: 32] : '0;
                    ctl_w[0] &= ~RX_STATUS;
                    ctl_w[0] |= (32'(r.rx_len - 8'd1) << 24) | RX_EOM | RX_GOOD;
                    ctl_w[4] |= RX_INT;
                    o.rx_p = 1'b1;
                    n_rx++;
                end
            end
            default: ;
        endcase
        o.plug = hp_level;
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------------
    cec_req_t cur_req;
    int       burst_left = 0;
    int       gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                rsp_due.push_back(cec_reg_update(cur_req));
                n_accepted++;
            end
            // a request still waiting for ready stays on the bus untouched
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (req_fifo.size() > 0) begin
                    cur_req = req_fifo.pop_front();
                    s_valid         <= 1'b1;
                    s_req_type      <= cur_req.kind;
                    s_address       <= cur_req.addr;
                    s_write_data    <= cur_req.wdata;
                    s_plug_level    <= cur_req.level;
                    s_rx_length     <= cur_req.rx_len;
                    s_rx_bytes_low  <= cur_req.rx_lo;
                    s_rx_bytes_high <= cur_req.rx_hi;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: stall pattern that switches mode every so often
    // ------------------------------------------------------------------------
    int stall_mode = 0;
    int mode_left  = 0;

    always @(posedge aclk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            2:       m_ready <= ($urandom_range(0, 2) == 0);
            default: m_ready <= mode_left[3];
        endcase
    end

    // Result monitor: each transfer is checked against the oldest prediction.
    always @(posedge aclk) begin
        cec_rsp_t got;
        cec_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_read_data, m_bad_offset, m_plug_now, m_plug_pulse,
                   m_unplug_pulse, m_tx_done_pulse, m_rx_pulse};
            if (rsp_due.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_REPORTS)
                    $display("stray result transfer: rdata %h bad %b", got.rdata, got.bad);
            end else begin
                want = rsp_due.pop_front();
                if (got !== want) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                        $display("mismatch exp/got: rdata %h/%h bad %b/%b plug %b/%b %s",
                                 want.rdata, got.rdata, want.bad, got.bad, want.plug, got.plug,
                                 $sformatf("pp %b/%b up %b/%b txd %b/%b rxp %b/%b",
                                           want.plug_p, got.plug_p, want.unplug_p,
                                           got.unplug_p, want.tx_done, got.tx_done,
                                           want.rx_p, got.rx_p));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic cec_req_t rand_req(logic [2:0] kind, logic [ADDR_W-1:0] addr,
                                          logic [WORD_W-1:0] data);
        cec_req_t r;
        r.kind   = kind;
        r.addr   = addr;
        r.wdata  = data;
        r.level  = 1'($urandom);
        r.rx_len = 8'($urandom);
        r.rx_lo  = {$urandom, $urandom};
        r.rx_hi  = {$urandom, $urandom};
        return r;
    endfunction

    task automatic put(input logic [2:0] kind, input logic [ADDR_W-1:0] addr,
                       input logic [WORD_W-1:0] data);
        req_fifo.push_back(rand_req(kind, addr, data));
    endtask

    task automatic put_rx(input logic [7:0] len, input logic [63:0] lo, input logic [63:0] hi);
        cec_req_t r;
        r = rand_req(REQ_RX, 6'($urandom), $urandom);
        r.rx_len = len;
        r.rx_lo = lo;
        r.rx_hi = hi;
        req_fifo.push_back(r);
    endtask

    task automatic put_plug(input logic lvl);
        cec_req_t r;
        r = rand_req(REQ_PLUG, 6'($urandom), $urandom);
        r.level = lvl;
        req_fifo.push_back(r);
    endtask

    // Wait until every queued request went out and every result came back.
    task automatic settle();
        do @(negedge aclk);
        while (req_fifo.size() != 0 || s_valid || rsp_due.size() != 0);
        repeat (2) @(negedge aclk);
    endtask

    // Only called with the block idle.
    task automatic cfg_set(input logic [15:0] mask, input logic nack, input logic [15:0] st,
                           input logic [15:0] bt, input logic conn);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PEER_ACK;
        cfg_wdata <= mask;
        @(posedge aclk);
        cfg_index <= CFG_FORCE_NACK;
        cfg_wdata <= 16'(nack);
        @(posedge aclk);
        cfg_index <= CFG_START;
        cfg_wdata <= st;
        @(posedge aclk);
        cfg_index <= CFG_BYTE;
        cfg_wdata <= bt;
        @(posedge aclk);
        cfg_index <= CFG_CONN_RST;
        cfg_wdata <= 16'(conn);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ack_mask  = mask;
        nack_all  = nack;
        start_len = st;
        byte_len  = bt;
        conn_rst  = conn;   // the block ignores it
        @(negedge aclk);
    endtask

    // Mostly whole transmit and receive sequences, with some plug changes
    // and raw noise; the sender drains once halfway through.
    task automatic rand_phase(input int n);
        int                made;
        int                k;
        bit                paused;
        logic [WORD_W-1:0] ctl;
        made = 0;
        paused = 1'b0;
        while (made < n) begin
            if (!paused && made >= n / 2) begin
                settle();
                paused = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    ctl = $urandom & ~START_TX;
                    if ($urandom_range(0, 3) != 0)
                        ctl[19:16] = 4'($urandom_range(0, 2));
                    put(REQ_WRITE, TXD_OFF, $urandom);
                    put(REQ_WRITE, CTL1_OFF, ctl);
                    put(REQ_WRITE, CTL1_OFF, ctl | START_TX);
                    k = $urandom_range(1, 40);
                    repeat (k) begin
                        case ($urandom_range(0, 31))
                            0:       put_rx(8'($urandom_range(1, 16)), {$urandom, $urandom},
                                            {$urandom, $urandom});
                            1:       put(REQ_WRITE, CTL5_OFF, $urandom | TX_SWRST);
                            2:       put_plug(1'($urandom));
                            3:       put(REQ_READ, CTL1_OFF, $urandom);
                            default: put(REQ_TICK, 6'($urandom), $urandom);
                        endcase
                    end
                    put(REQ_READ, CTL1_OFF, $urandom);
                    made += k + 4;
                end
                5, 6: begin
                    if ($urandom_range(0, 3) != 0)
                        put(REQ_WRITE, CTL5_OFF, $urandom & ~(TX_SWRST | RX_SWRST));
                    else
                        put(REQ_WRITE, CTL5_OFF, $urandom);
                    put_rx(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 16)),
                           {$urandom, $urandom}, {$urandom, $urandom});
                    put(REQ_READ, RXD_OFF + 6'($urandom_range(0, 7)), $urandom);
                    put(REQ_READ, CTL1_OFF, $urandom);
                    put(REQ_WRITE, CTL1_OFF, ($urandom & ~START_TX) | CLR_RX);
                    made += 5;
                end
                7: begin
                    put_plug($urandom_range(0, 3) != 0);
                    made += 1;
                end
                default: begin
                    repeat (4) put(3'($urandom), 6'($urandom), $urandom);
                    made += 4;
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        ack_mask  = 16'd1;
        nack_all  = 1'b0;
        start_len = 16'd5;
        byte_len  = 16'd24;
        conn_rst  = 1'b1;
        hp_level  = 1'b1;
        for (int i = 0; i < 5; i++)
            ctl_w[i] = '0;
        for (int i = 0; i < 4; i++) begin
            txd_w[i] = '0;
            rxd_w[i] = '0;
        end
        tx_active = 1'b0;
        tx_left   = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // short frames so directed transmissions end within a few ticks
        cfg_set(16'h8001, 1'b0, 16'd1, 16'd1, 1'b1);
        put(REQ_READ, 6'h00, '1);               // below the map
        put(REQ_READ, 6'h21, '0);               // unaligned just past control word 5
        put(REQ_READ, 6'h3f, '0);               // last receive byte
        put(REQ_WRITE, 6'h11, '1);              // unaligned control word 1
        put(REQ_WRITE, 6'h23, '1);
        put(REQ_WRITE, RXD_OFF, '1);            // receive words ignore writes
        put(REQ_WRITE, TXD_OFF, 32'h0000_000f); // broadcast destination
        put(REQ_WRITE, CTL1_OFF, START_TX);     // one byte frame
        repeat (3) put(REQ_TICK, '0, '0);       // last tick lands on an idle block
        put(REQ_WRITE, CTL1_OFF, '1);           // status kept, start already high
        put(REQ_READ, CTL1_OFF, '0);
        put_rx(8'd0, '1, '1);
        put_rx(8'd16, '1, '1);
        put(REQ_READ, 6'h3c, '0);
        put_rx(8'd17, '1, '1);
        put_rx(8'd255, '1, '1);
        put_rx(8'd5, 64'h0123_4567_89ab_cdef, '1);
        put_plug(1'b0);
        put_rx(8'd3, '1, '1);                   // dropped while unplugged
        put_plug(1'b0);
        put_plug(1'b1);
        put(REQ_WRITE, CTL5_OFF, TX_SWRST | RX_SWRST);
        put_rx(8'd4, '1, '1);                   // dropped under receive reset
        put(REQ_WRITE, CTL5_OFF, '0);
        put(REQ_SPARE_LO, '1, '1);
        put(REQ_SPARE_HI, '1, '1);
        rand_phase(RAND_PER_PHASE);

        for (int ph = 1; ph < N_PHASES; ph++) begin
            settle();
            case (ph)
                1:       cfg_set(16'hffff, 1'b0, 16'h0000, 16'h0000, 1'b0);
                2:       cfg_set(16'h0000, 1'b1, 16'hffff, 16'hffff, 1'b1);
                3:       cfg_set(16'h0001, 1'b0, 16'd5, 16'd24, 1'b1);
                default: cfg_set(16'($urandom), 1'($urandom), 16'($urandom_range(0, 12)),
                                 16'($urandom_range(0, 4)), 1'($urandom));
            endcase
            rand_phase(RAND_PER_PHASE);
        end

        settle();
        repeat (4) @(negedge aclk);
        n_fail += rsp_due.size();
        $display("covered %0d requests over %0d settings: %0d frames sent, %0d messages latched",
                 n_accepted, N_PHASES, n_tx_done, n_rx);
        $display("%0d hot-plug edges seen, %0d bad result transfers", n_edges, n_fail);
        if (n_fail == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // hang guard: ends the run as a failure
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

/* cec_controller_registers_core.f */
src/cecr_pkg.sv
src/cecr_decode.sv
src/cec_controller_registers_core.sv
src/cecr_checker.sv
dv/tb_cec_controller_registers_core.sv
